/* hdl/tsu_pkg.sv */
// Shared constants for the timestamp unwrap and discontinuity fix block.
`default_nettype none
package tsu_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_START_TIME_VALID = 3'd0;
   localparam logic [2:0] REG_START_TIME       = 3'd1;
   localparam logic [2:0] REG_WRAP_BITS        = 3'd2;
   localparam logic [2:0] REG_TICKS_PER_SECOND = 3'd3;
   localparam logic [2:0] REG_FIRST_DTS_LEAD   = 3'd4;

   // configuration port widths
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // field widths
   localparam int FIELD_W    = 64;
   localparam int DUR_W      = 32;
   localparam int WRAP_W     = 7;
   localparam int LEAD_W     = 33;
   localparam int TPS_W      = 32;
   localparam int THR_BIG_W  = 36;
   localparam int THR_SMALL_W = 29;

   // floor(x / 10) = (x * RECIP10) >> RECIP10_SHIFT for every 32-bit x
   localparam logic [63:0] RECIP10       = 64'h0000_0000_CCCC_CCCD;
   localparam int          RECIP10_SHIFT = 35;

   // largest wrap width that still enables unwrapping
   localparam logic [WRAP_W-1:0] WRAP_MAX = 7'd63;
   localparam logic [WRAP_W-1:0] WRAP_MIN = 7'd1;

   // stream packing
   localparam int REQ_DATA_W = 160;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 192;
   localparam int RSP_USER_W = 3;

   localparam int REQ_USER_DTS_PRESENT = 0;
   localparam int REQ_USER_PTS_PRESENT = 1;
   localparam int RSP_USER_DTS_PRESENT = 0;
   localparam int RSP_USER_PTS_PRESENT = 1;
   localparam int RSP_USER_DISC        = 2;

   // reset values of the registers
   localparam logic [WRAP_W-1:0]      WRAP_RESET      = 7'd33;
   localparam logic [THR_BIG_W-1:0]   THR_BIG_RESET   = 36'd900000;
   localparam logic [THR_SMALL_W-1:0] THR_SMALL_RESET = 29'd9000;

endpackage
`default_nettype wire

/* hdl/timestamp_unwrap_discontinuity_fix_core.sv */
// Top level of the timestamp unwrap and discontinuity fix block.
//
// Usage:
//   req_* carries one packet per beat: optional DTS and PTS and a duration.
//   rsp_* returns one beat per packet: corrected stamps, a discontinuity flag
//   and the current stamp assigned to the packet.
//   csr_* writes the configuration registers; write only while the block is
//   empty. A write to ticks_per_second derives both thresholds at once.
// Pipeline: a req beat passes the input register, then the result register.
//   Throughput: one packet per cycle while rsp_tready is high; the running offset,
//   current and next stamps are updated in the same cycle as the result
//   register loads, so consecutive packets chain without a bubble.
// Reset (synchronous, active high) clears the stream state and restores the
//   register defaults; no clearing pass is needed.
// Stall: when rsp_tready is low the result is held, the input register fills
//   and req_tready drops once both stages hold a packet.
`default_nettype none
module timestamp_unwrap_discontinuity_fix_core
   import tsu_pkg::*;
#(
   parameter int STAMP_BITS = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata: in_dts[63:0], in_pts[127:64], duration[159:128]
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: dts_present[0], pts_present[1]
   input  wire logic [REQ_USER_W-1:0]  req_tuser,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // rsp_tdata: out_dts[63:0], out_pts[127:64], expected_dts[191:128]
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   // rsp_tuser: out_dts_present[0], out_pts_present[1], discontinuity[2]
   output logic [RSP_USER_W-1:0]       rsp_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef logic signed [STAMP_BITS-1:0] stamp_type;

   localparam stamp_type STAMP_ONE  = stamp_type'(1);
   localparam stamp_type STAMP_ZERO = stamp_type'(0);

   // configuration registers
   logic                   start_valid_ff;
   stamp_type              start_time_ff;
   logic [WRAP_W-1:0]      wrap_bits_ff;
   logic [THR_BIG_W-1:0]   thr_big_ff;
   logic [THR_SMALL_W-1:0] thr_small_ff;
   logic signed [LEAD_W-1:0] lead_ff;
   logic [63:0]            recip_prod;

   // stream state
   logic      started_ff, started_in;
   logic      offset_set_ff, offset_set_in;
   stamp_type offset_ff, offset_in;
   stamp_type current_ff, current_in;
   stamp_type next_ff, next_in;

   // input register
   logic             s1_valid_ff;
   logic             s1_dp_ff, s1_pp_ff;
   stamp_type        s1_dts_ff, s1_pts_ff;
   logic [DUR_W-1:0] s1_dur_ff;
   logic             s1_move;

   // result register
   logic      rsp_valid_ff;
   logic      rsp_dp_ff, rsp_pp_ff, rsp_disc_ff;
   stamp_type rsp_dts_ff, rsp_pts_ff, rsp_exp_ff;
   logic      disc_in;
   stamp_type dts_out_in, pts_out_in;

   // datapath nets
   logic      unwrap_en, wrap_ok, init_off, jump, mag_big, below_cur;
   stamp_type period, half, st_wrap, st_half;
   stamp_type dts_u, pts_u, off, dts_c, pts_c, delta, delta_neg, mag_s;
   stamp_type thr_small_s, dur_s, lead_s, first_cur;
   logic [63:0] mag64;

   // ---------------------------------------------------------------
   // configuration writes; derive thresholds at write time
   assign recip_prod = 64'(csr_wdata[TPS_W-1:0]) * RECIP10;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_valid_ff <= 1'b0;
         start_time_ff  <= STAMP_ZERO;
         wrap_bits_ff   <= WRAP_RESET;
         thr_big_ff     <= THR_BIG_RESET;
         thr_small_ff   <= THR_SMALL_RESET;
         lead_ff        <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_START_TIME_VALID: start_valid_ff <= csr_wdata[0];
            REG_START_TIME:       start_time_ff  <= stamp_type'(csr_wdata[STAMP_BITS-1:0]);
            REG_WRAP_BITS:        wrap_bits_ff   <= csr_wdata[WRAP_W-1:0];
            REG_TICKS_PER_SECOND: begin
               thr_big_ff   <= (THR_BIG_W'(csr_wdata[TPS_W-1:0]) << 3)
                             + (THR_BIG_W'(csr_wdata[TPS_W-1:0]) << 1);
               thr_small_ff <= recip_prod[RECIP10_SHIFT +: THR_SMALL_W];
            end
            REG_FIRST_DTS_LEAD:   lead_ff        <= $signed(csr_wdata[LEAD_W-1:0]);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // handshake: input register advances when the result slot frees
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_dp_ff  <= req_tuser[REQ_USER_DTS_PRESENT];
         s1_pp_ff  <= req_tuser[REQ_USER_PTS_PRESENT];
         s1_dts_ff <= stamp_type'(req_tdata[STAMP_BITS-1:0]);
         s1_pts_ff <= stamp_type'(req_tdata[FIELD_W +: STAMP_BITS]);
         s1_dur_ff <= req_tdata[2*FIELD_W +: DUR_W];
      end
   end

   // ---------------------------------------------------------------
   // unwrap against start time
   always_comb begin
      unwrap_en = start_valid_ff && (wrap_bits_ff >= WRAP_MIN) && (wrap_bits_ff <= WRAP_MAX);
      period    = STAMP_ONE << wrap_bits_ff;
      half      = STAMP_ONE << (wrap_bits_ff - WRAP_MIN);
      st_wrap   = start_time_ff + period;
      st_half   = start_time_ff + half;
      wrap_ok   = unwrap_en && (st_wrap > start_time_ff);
      dts_u     = (wrap_ok && (s1_dts_ff > st_half)) ? s1_dts_ff - period : s1_dts_ff;
      pts_u     = (wrap_ok && (s1_pts_ff > st_half)) ? s1_pts_ff - period : s1_pts_ff;
   end

   // apply the running offset; with unwrapping enabled, the first packet seeds it from the start time
   always_comb begin
      init_off = unwrap_en && !started_ff && !offset_set_ff;
      if (init_off) begin
         off = -start_time_ff;
      end else if (offset_set_ff) begin
         off = offset_ff;
      end else begin
         off = STAMP_ZERO;
      end
      dts_c = dts_u + off;
      pts_c = pts_u + off;
   end

   // check the decode stamp against the prediction
   always_comb begin
      thr_small_s = $signed({{(STAMP_BITS-THR_SMALL_W){1'b0}}, thr_small_ff});
      delta       = dts_c - next_ff;
      delta_neg   = -delta;
      mag_s       = delta[STAMP_BITS-1] ? delta_neg : delta;
      mag64       = 64'(mag_s);
      mag_big     = mag64 > {{(64-THR_BIG_W){1'b0}}, thr_big_ff};
      below_cur   = current_ff > (dts_c + thr_small_s);
      jump        = s1_dp_ff && started_ff && (mag_big || below_cur);
      disc_in     = jump;
      dts_out_in  = jump ? next_ff : dts_c;
      pts_out_in  = jump ? pts_c - delta : pts_c;
   end

   // advance offset, current and predicted stamps
   always_comb begin
      dur_s     = $signed({{(STAMP_BITS-DUR_W){1'b0}}, s1_dur_ff});
      lead_s    = stamp_type'(lead_ff);
      first_cur = lead_s + (s1_pp_ff ? pts_out_in : STAMP_ZERO);
      if (s1_dp_ff) begin
         current_in = dts_out_in;
      end else if (started_ff) begin
         current_in = next_ff;
      end else begin
         current_in = first_cur;
      end
      next_in    = current_in + dur_s;
      started_in = 1'b1;
      if (jump) begin
         offset_in     = off - delta;
         offset_set_in = 1'b1;
      end else if (init_off) begin
         offset_in     = off;
         offset_set_in = 1'b1;
      end else begin
         offset_in     = offset_ff;
         offset_set_in = offset_set_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         offset_set_ff <= 1'b0;
         offset_ff     <= STAMP_ZERO;
         current_ff    <= STAMP_ZERO;
         next_ff       <= STAMP_ZERO;
      end else if (s1_move) begin
         started_ff    <= started_in;
         offset_set_ff <= offset_set_in;
         offset_ff     <= offset_in;
         current_ff    <= current_in;
         next_ff       <= next_in;
      end
   end

   // ---------------------------------------------------------------
   // result register; hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_dp_ff   <= s1_dp_ff;
         rsp_pp_ff   <= s1_pp_ff;
         rsp_disc_ff <= disc_in;
         rsp_dts_ff  <= s1_dp_ff ? dts_out_in : STAMP_ZERO;
         rsp_pts_ff  <= s1_pp_ff ? pts_out_in : STAMP_ZERO;
         rsp_exp_ff  <= current_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {64'(rsp_exp_ff), 64'(rsp_pts_ff), 64'(rsp_dts_ff)};
   assign rsp_tuser  = {rsp_disc_ff, rsp_pp_ff, rsp_dp_ff};

   // ---------------------------------------------------------------
   // checks
   a_disc_needs_dts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[RSP_USER_DISC] |-> rsp_tuser[RSP_USER_DTS_PRESENT])
      else $error("discontinuity flagged without a decode stamp");

   a_expected_is_dts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[RSP_USER_DTS_PRESENT]
         |-> rsp_tdata[2*FIELD_W +: FIELD_W] == rsp_tdata[FIELD_W-1:0])
      else $error("current stamp differs from the corrected decode stamp");

   a_started_holds: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("stream start flag dropped without reset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled while a stage was free");

endmodule
`default_nettype wire

/* tb/sv/tb_timestamp_unwrap_discontinuity_fix_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the timestamp unwrap and discontinuity fix core.
module tb_timestamp_unwrap_discontinuity_fix_core;
   import tsu_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          SEGMENTS    = 7;
   localparam int          SEG_PACKETS = 85;

   typedef struct {
      logic        dts_p;
      logic [63:0] dts;
      logic        pts_p;
      logic [63:0] pts;
      logic [31:0] dur;
   } packet_type;

   typedef struct {
      logic        dts_p;
      logic [63:0] dts;
      logic        pts_p;
      logic [63:0] pts;
      logic        disc;
      logic [63:0] cur;
   } stamp_fix_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // stimulus and scoreboard
   packet_type    pending_pkts[$];
   stamp_fix_type awaited_fixes[$];
   packet_type    beat_on_bus;
   stamp_fix_type due_fix;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;
   logic [63:0] src_stamp     = '0;

   // predictor copy of the registers
   logic        cfg_start_valid = 1'b0;
   logic [63:0] cfg_start       = '0;
   logic [6:0]  cfg_wrap        = WRAP_RESET;
   logic [31:0] cfg_tps         = 32'd90000;
   logic [63:0] cfg_lead        = '0;

   // predictor copy of the stream state
   logic        strm_started = 1'b0;
   logic        offs_valid   = 1'b0;
   logic [63:0] stamp_offset = '0;
   logic [63:0] cur_stamp    = '0;
   logic [63:0] next_stamp   = '0;

   // default stamp width of 64 bits, which the predictor assumes
   timestamp_unwrap_discontinuity_fix_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // move a stamp above start + half a wrap period down by one period
   function automatic logic [63:0] unwrap_stamp(logic [63:0] v);
      logic [63:0] period;
      logic [63:0] half;
      period = 64'd1 << cfg_wrap;
      half   = 64'd1 << (cfg_wrap - 7'd1);
      if ($signed(cfg_start + period) > $signed(cfg_start) &&
          $signed(v) > $signed(cfg_start + half))
         return v - period;
      return v;
   endfunction

   // corrected stamps and current stamp for one packet; advances the stream state
   function automatic stamp_fix_type predict_fix(packet_type p);
      stamp_fix_type f;
      logic [63:0] dts;
      logic [63:0] pts;
      logic [63:0] big;
      logic [63:0] lim;
      logic [63:0] off;
      logic [63:0] delta;
      logic [63:0] mag;
      logic        enable;
      dts    = p.dts;
      pts    = p.pts;
      big    = {32'd0, cfg_tps} * 64'd10;
      lim    = {32'd0, cfg_tps / 32'd10};
      enable = cfg_start_valid && cfg_wrap >= WRAP_MIN && cfg_wrap <= WRAP_MAX;
      f.disc = 1'b0;

      // seed the offset from the start time before the first packet
      if (enable) begin
         if (!strm_started && !offs_valid) begin
            stamp_offset = 64'd0 - cfg_start;
            offs_valid   = 1'b1;
         end
         if (p.dts_p) dts = unwrap_stamp(dts);
         if (p.pts_p) pts = unwrap_stamp(pts);
      end

      off = offs_valid ? stamp_offset : 64'd0;
      if (p.dts_p) dts = dts + off;
      if (p.pts_p) pts = pts + off;

      // fold a jump into the offset
      if (p.dts_p && strm_started) begin
         delta = dts - next_stamp;
         mag   = delta[63] ? 64'd0 - delta : delta;
         if (mag > big || $signed(cur_stamp) > $signed(dts + lim)) begin
            stamp_offset = off - delta;
            offs_valid   = 1'b1;
            dts          = dts - delta;
            if (p.pts_p) pts = pts - delta;
            f.disc = 1'b1;
         end
      end

      if (!strm_started) begin
         cur_stamp    = cfg_lead + (p.pts_p ? pts : 64'd0);
         next_stamp   = cur_stamp;
         strm_started = 1'b1;
      end
      if (p.dts_p) next_stamp = dts;
      cur_stamp  = next_stamp;
      next_stamp = next_stamp + {32'd0, p.dur};

      f.dts_p = p.dts_p;
      f.dts   = p.dts_p ? dts : 64'd0;
      f.pts_p = p.pts_p;
      f.pts   = p.pts_p ? pts : 64'd0;
      f.cur   = cur_stamp;
      return f;
   endfunction

   // wrap a source stamp into the counter width when unwrapping can apply
   function automatic logic [63:0] raw_counter(logic [63:0] v);
      if (cfg_wrap >= WRAP_MIN && cfg_wrap <= WRAP_MAX)
         return v & ((64'd1 << cfg_wrap) - 64'd1);
      return v;
   endfunction

   function automatic void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) flag_error($sformatf("%s: expected %h, got %h", name, want, got));
   endfunction

   function automatic void queue_pkt(logic dp, logic [63:0] dts, logic pp,
                                     logic [63:0] pts, logic [31:0] dur);
      packet_type p;
      p.dts_p = dp;
      p.dts   = dts;
      p.pts_p = pp;
      p.pts   = pts;
      p.dur   = dur;
      pending_pkts.push_back(p);
   endfunction

   // one register write, mirrored into the predictor
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_START_TIME_VALID: cfg_start_valid = val[0];
         REG_START_TIME:       cfg_start       = val;
         REG_WRAP_BITS:        cfg_wrap        = val[6:0];
         REG_TICKS_PER_SECOND: cfg_tps         = val[31:0];
         REG_FIRST_DTS_LEAD:   cfg_lead        = {{31{val[32]}}, val[32:0]};
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // write every register with junk above the used bits, plus an unmapped index
   task automatic load_settings(logic stv, logic [63:0] st, logic [6:0] wb,
                                logic [31:0] tps, logic [32:0] lead);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_reg(REG_START_TIME_VALID, {junk[63:1], stv});
      write_reg(REG_START_TIME, st);
      write_reg(REG_WRAP_BITS, {junk[63:7], wb});
      write_reg(REG_TICKS_PER_SECOND, {junk[63:32], tps});
      write_reg(REG_FIRST_DTS_LEAD, {junk[63:33], lead});
      write_reg(REG_FIRST_DTS_LEAD + CSR_INDEX_W'($urandom_range(1, 3)), junk);
      // start the source clock a little before the start time
      src_stamp = cfg_start - $urandom_range(0, 400000);
   endtask

   // drive packet beats from the pending queue, predicting each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_fixes.push_back(predict_fix(beat_on_bus));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_pkts.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               beat_on_bus = pending_pkts.pop_front();
               req_tdata  <= {beat_on_bus.dur, beat_on_bus.pts, beat_on_bus.dts};
               req_tuser  <= {beat_on_bus.pts_p, beat_on_bus.dts_p};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // check result beats against the oldest prediction; stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_fixes.size() == 0) begin
               flag_error($sformatf("result beat with nothing awaited, tdata %h", rsp_tdata));
            end else begin
               due_fix = awaited_fixes.pop_front();
               check_field("out_dts_present", 64'(due_fix.dts_p),
                           64'(rsp_tuser[RSP_USER_DTS_PRESENT]));
               check_field("out_dts", due_fix.dts, rsp_tdata[63:0]);
               check_field("out_pts_present", 64'(due_fix.pts_p),
                           64'(rsp_tuser[RSP_USER_PTS_PRESENT]));
               check_field("out_pts", due_fix.pts, rsp_tdata[127:64]);
               check_field("discontinuity", 64'(due_fix.disc), 64'(rsp_tuser[RSP_USER_DISC]));
               check_field("expected_dts", due_fix.cur, rsp_tdata[191:128]);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_timestamp_unwrap_discontinuity_fix_core failed");
         $finish;
      end
   end

   initial begin
      packet_type  p;
      logic [63:0] st;
      logic [63:0] step;
      int          seg;
      int          kind;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (seg = 0; seg < SEGMENTS; seg++) begin
         // sender idles lightly first, then the receiver, then neither
         if (seg < 2) begin
            send_idle_pct = 18;
            recv_idle_pct = 83;
         end else if (seg < 4) begin
            send_idle_pct = 83;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         case (seg)
            // the first packet either seeds the offset or leaves it unset
            0: load_settings(1'($urandom_range(0, 1)), 64'($urandom_range(0, 1000000)),
                             7'd33, 32'd90000, 33'd0 - 33'($urandom_range(0, 9009)));
            1: load_settings(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 7'd63, 32'hFFFF_FFFF,
                             33'h1_0000_0000);
            2: load_settings(1'b1, 64'h8000_0000_0000_0000, 7'd1, 32'd0, 33'd0);
            3: load_settings(1'b0, {$urandom, $urandom}, 7'd127, 32'd1, {1'b1, $urandom});
            4: load_settings(1'b1, 64'($urandom_range(0, 1 << 30)), 7'd0, 32'd90000,
                             {1'b1, $urandom});
            5: load_settings(1'b1, 64'($urandom_range(0, 1 << 30)), 7'd64, 32'd27000000,
                             {1'b1, $urandom});
            default: load_settings(1'b1, 64'($urandom_range(0, 1 << 30)),
                                   7'($urandom_range(2, 40)),
                                   32'($urandom_range(1000, 1000000)), {1'b1, $urandom});
         endcase

         // directed packets: first packet, missing stamps, jumps, wrap, extremes
         if (seg == 0) begin
            st = cfg_start;
            queue_pkt(1'b1, st + 64'd3003, 1'b1, st + 64'd6006, 32'd3003);
            queue_pkt(1'b1, st + 64'd6006, 1'b1, st + 64'd9009, 32'd3003);
            queue_pkt(1'b0, st + 64'd9009, 1'b1, st + 64'd12012, 32'd3003);
            queue_pkt(1'b1, st + 64'd12012, 1'b0, st, 32'd3003);
            queue_pkt(1'b0, st, 1'b0, st, 32'd3003);
            queue_pkt(1'b1, st + 64'd5000000, 1'b1, st + 64'd5003003, 32'd3003);
            queue_pkt(1'b1, st + 64'd5003003, 1'b1, st + 64'd5006006, 32'd3003);
            queue_pkt(1'b1, st + 64'd4980000, 1'b1, st + 64'd4983003, 32'd3003);
            queue_pkt(1'b1, st, 1'b1, st + 64'd3003, 32'd3003);
            queue_pkt(1'b1, st + (64'd1 << 33) - 64'd1000, 1'b1,
                      st + (64'd1 << 33) + 64'd2003, 32'd3003);
            queue_pkt(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'h8000_0000_0000_0000,
                      32'hFFFF_FFFF);
            queue_pkt(1'b1, 64'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
            queue_pkt(1'b1, 64'h8000_0000_0000_0000, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 32'd1);
            queue_pkt(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0, 32'd3003);
            queue_pkt(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
                      32'hFFFF_FFFF);
            queue_pkt(1'b1, st + 64'd90000, 1'b1, st + 64'd93003, 32'd3003);
         end

         // mostly a running source clock, with jumps, falls, gaps and noise
         repeat (SEG_PACKETS) begin
            kind = $urandom_range(0, 99);
            if (kind >= 70 && kind < 78) begin
               step      = 64'($urandom) << $urandom_range(0, 31);
               src_stamp = $urandom_range(0, 1) ? src_stamp + step : src_stamp - step;
            end else if (kind >= 78 && kind < 84) begin
               src_stamp = src_stamp - $urandom_range(1, 50000);
            end
            if (kind >= 90) begin
               p.dts_p = 1'($urandom_range(0, 1));
               p.dts   = {$urandom, $urandom};
               p.pts_p = 1'($urandom_range(0, 1));
               p.pts   = {$urandom, $urandom};
               p.dur   = $urandom;
            end else begin
               p.dur   = 32'($urandom_range(0, 6000));
               p.dts_p = (kind < 84) ? ($urandom_range(0, 19) != 0) : 1'b0;
               p.dts   = raw_counter(src_stamp);
               p.pts_p = ($urandom_range(0, 9) != 0);
               p.pts   = raw_counter(src_stamp + $urandom_range(0, 9000));
               src_stamp = src_stamp + {32'd0, p.dur};
            end
            pending_pkts.push_back(p);
         end

         // hold until the block is empty before touching the registers again;
         // sample away from the rising edge so the driver's updates have settled
         while (pending_pkts.size() != 0 || req_tvalid || awaited_fixes.size() != 0)
            @(negedge clock);
         repeat (4) @(posedge clock);
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && awaited_fixes.size() == 0) begin
         $display("tb_timestamp_unwrap_discontinuity_fix_core passed");
      end else begin
         $display("tb_timestamp_unwrap_discontinuity_fix_core failed");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/tsu_pkg.sv
hdl/timestamp_unwrap_discontinuity_fix_core.sv
tb/sv/tb_timestamp_unwrap_discontinuity_fix_core.sv
